// ===== design/mrm_pkg.sv =====
// Package for the message receive matcher: transaction types, queue entry
// layouts, outcome codes and the controller/datapath command and status groups.
// No dependencies.
package mrm_pkg;

    // Outcome codes reported with each result transaction
    localparam logic [2:0] OUT_MSG_MATCHED  = 3'd0;
    localparam logic [2:0] OUT_MSG_QUEUED   = 3'd1;
    localparam logic [2:0] OUT_RECV_MATCHED = 3'd2;
    localparam logic [2:0] OUT_RECV_POSTED  = 3'd3;
    localparam logic [2:0] OUT_OVERFLOW     = 3'd4;

    // Command codes of an input transaction
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_POST   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] source_rank;
        logic [15:0] msg_length;
        logic [15:0] msg_ref;
        logic [15:0] dest_ref;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [15:0] recv_handle_out;
        logic [15:0] match_rank;
        logic [15:0] match_length;
        logic [15:0] match_msg_ref;
        logic [15:0] match_dest_ref;
        logic [5:0]  posted_count;
        logic [5:0]  unexpected_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] rank;
        logic [15:0] dest;
    } t_pq_entry;

    typedef struct packed {
        logic [15:0] rank;
        logic [15:0] length;
        logic [15:0] ref_id;
    } t_uq_entry;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture input, clear index, assign handle
        logic rd_en;     // read searched queue
        logic rd_next;   // read at index + 1 instead of index
        logic take;      // capture matching entry
        logic idx_inc;
        logic shift_wr;  // write read data back at index (gap closing)
        logic append;    // append input to the other queue
        logic drop;      // mark overflow
        logic fill_dec;  // searched queue loses one entry
        logic out_load;  // build result register
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic scan_end;  // index reached fill of searched queue
        logic hit;       // read data rank equals input rank
        logic last;      // index is the last occupied entry
        logic full;      // queue to append to is full
    } t_ctl_sts;

endpackage

// ===== design/mrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mrm_ctrl.sv =====
// Sequencing state machine of the matcher: scan, gap closing, append, result.
// Depends on mrm_pkg.
module mrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mrm_pkg::t_ctl_cmd o_cmd,
    input  mrm_pkg::t_ctl_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_APPEND,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_APPEND;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SHIFT_CHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_CHK: begin
                if (i_sts.last) begin
                    o_cmd.fill_dec = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_CHK;
            end
            S_APPEND: begin
                if (i_sts.full) begin
                    o_cmd.drop = 1'b1;
                end else begin
                    o_cmd.append = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/mrm_dpath.sv =====
// Datapath of the matcher: both queue RAMs, fill counters, handle counter,
// scan index, match capture and the result register.
// Depends on mrm_pkg and mrm_ram.
module mrm_dpath #(
    parameter int POSTED_DEPTH     = 32,
    parameter int UNEXPECTED_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrm_pkg::t_in_item  i_in_data,
    output mrm_pkg::t_out_item o_out_data,
    input  mrm_pkg::t_ctl_cmd  i_cmd,
    output mrm_pkg::t_ctl_sts  o_sts
);

    localparam int PAW  = (POSTED_DEPTH > 1) ? $clog2(POSTED_DEPTH) : 1;
    localparam int UAW  = (UNEXPECTED_DEPTH > 1) ? $clog2(UNEXPECTED_DEPTH) : 1;
    localparam int PFW  = $clog2(POSTED_DEPTH + 1);
    localparam int UFW  = $clog2(UNEXPECTED_DEPTH + 1);
    localparam int MAXD = (POSTED_DEPTH > UNEXPECTED_DEPTH) ? POSTED_DEPTH
                                                            : UNEXPECTED_DEPTH;
    localparam int IW   = $clog2(MAXD + 1);

    mrm_pkg::t_in_item  r_in;
    mrm_pkg::t_pq_entry r_match_p;
    mrm_pkg::t_uq_entry r_match_u;
    mrm_pkg::t_out_item r_out;
    logic [PFW-1:0]     r_pfill;
    logic [UFW-1:0]     r_ufill;
    logic [15:0]        r_next_handle;
    logic [15:0]        r_post_handle;
    logic [IW-1:0]      r_idx;
    logic               r_hit;
    logic               r_drop;

    mrm_pkg::t_pq_entry p_rd, p_wr_data;
    mrm_pkg::t_uq_entry u_rd, u_wr_data;
    logic               p_wr_en, u_wr_en;
    logic [PAW-1:0]     p_wr_addr;
    logic [UAW-1:0]     u_wr_addr;
    logic               p_rd_en, u_rd_en;
    logic [IW-1:0]      rd_idx;
    logic [IW-1:0]      idx_plus;
    logic [IW-1:0]      s_fill;
    logic               is_post;

    assign is_post  = (r_in.command == mrm_pkg::CMD_POST);
    assign idx_plus = r_idx + IW'(1);
    assign rd_idx   = i_cmd.rd_next ? idx_plus : r_idx;
    assign s_fill   = is_post ? IW'(r_ufill) : IW'(r_pfill);

    // Arrivals search the posted queue, posts search the unexpected queue.
    assign p_rd_en = i_cmd.rd_en && !is_post;
    assign u_rd_en = i_cmd.rd_en && is_post;

    always_comb begin
        p_wr_en   = 1'b0;
        p_wr_addr = r_idx[PAW-1:0];
        p_wr_data = p_rd;
        u_wr_en   = 1'b0;
        u_wr_addr = r_idx[UAW-1:0];
        u_wr_data = u_rd;
        if (is_post) begin
            u_wr_en = i_cmd.shift_wr;
            if (i_cmd.append) begin
                p_wr_en          = 1'b1;
                p_wr_addr        = r_pfill[PAW-1:0];
                p_wr_data.handle = r_post_handle;
                p_wr_data.rank   = r_in.source_rank;
                p_wr_data.dest   = r_in.dest_ref;
            end
        end else begin
            p_wr_en = i_cmd.shift_wr;
            if (i_cmd.append) begin
                u_wr_en          = 1'b1;
                u_wr_addr        = r_ufill[UAW-1:0];
                u_wr_data.rank   = r_in.source_rank;
                u_wr_data.length = r_in.msg_length;
                u_wr_data.ref_id = r_in.msg_ref;
            end
        end
    end

    mrm_ram #(.WIDTH($bits(mrm_pkg::t_pq_entry)), .DEPTH(POSTED_DEPTH)) u_posted_ram (
        .i_clk     (i_clk),
        .i_wr_en   (p_wr_en),
        .i_wr_addr (p_wr_addr),
        .i_wr_data (p_wr_data),
        .i_rd_en   (p_rd_en),
        .i_rd_addr (rd_idx[PAW-1:0]),
        .o_rd_data (p_rd)
    );

    mrm_ram #(.WIDTH($bits(mrm_pkg::t_uq_entry)), .DEPTH(UNEXPECTED_DEPTH)) u_unex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (u_wr_en),
        .i_wr_addr (u_wr_addr),
        .i_wr_data (u_wr_data),
        .i_rd_en   (u_rd_en),
        .i_rd_addr (rd_idx[UAW-1:0]),
        .o_rd_data (u_rd)
    );

    assign o_sts.scan_end = (r_idx == s_fill);
    assign o_sts.hit      = is_post ? (u_rd.rank == r_in.source_rank)
                                    : (p_rd.rank == r_in.source_rank);
    assign o_sts.last     = (idx_plus == s_fill);
    assign o_sts.full     = is_post ? (r_pfill == PFW'(POSTED_DEPTH))
                                    : (r_ufill == UFW'(UNEXPECTED_DEPTH));

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfill       <= '0;
            r_ufill       <= '0;
            r_next_handle <= '0;
            r_idx         <= '0;
            r_hit         <= 1'b0;
            r_drop        <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_drop <= 1'b0;
                if (i_in_data.command == mrm_pkg::CMD_POST) begin
                    r_next_handle <= r_next_handle + 16'd1;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= idx_plus;
            end
            if (i_cmd.take) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.fill_dec) begin
                if (is_post) begin
                    r_ufill <= r_ufill - UFW'(1);
                end else begin
                    r_pfill <= r_pfill - PFW'(1);
                end
            end
            if (i_cmd.append) begin
                if (is_post) begin
                    r_pfill <= r_pfill + PFW'(1);
                end else begin
                    r_ufill <= r_ufill + UFW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in          <= i_in_data;
            r_post_handle <= r_next_handle;
        end
        if (i_cmd.take) begin
            r_match_p <= p_rd;
            r_match_u <= u_rd;
        end
        if (i_cmd.out_load) begin
            r_out.match_rank       <= r_in.source_rank;
            r_out.posted_count     <= 6'(r_pfill);
            r_out.unexpected_count <= 6'(r_ufill);
            if (is_post) begin
                r_out.recv_handle_out <= r_post_handle;
                r_out.match_dest_ref  <= r_in.dest_ref;
                r_out.match_length    <= r_hit ? r_match_u.length : 16'd0;
                r_out.match_msg_ref   <= r_hit ? r_match_u.ref_id : 16'd0;
                r_out.outcome         <= r_hit  ? mrm_pkg::OUT_RECV_MATCHED :
                                         r_drop ? mrm_pkg::OUT_OVERFLOW
                                                : mrm_pkg::OUT_RECV_POSTED;
            end else begin
                r_out.recv_handle_out <= r_hit ? r_match_p.handle : 16'd0;
                r_out.match_dest_ref  <= r_hit ? r_match_p.dest : 16'd0;
                r_out.match_length    <= r_in.msg_length;
                r_out.match_msg_ref   <= r_in.msg_ref;
                r_out.outcome         <= r_hit  ? mrm_pkg::OUT_MSG_MATCHED :
                                         r_drop ? mrm_pkg::OUT_OVERFLOW
                                                : mrm_pkg::OUT_MSG_QUEUED;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== design/message_receive_matcher.sv =====
// Top level of the message receive matcher: posted/unexpected queue matching
// on source rank. Depends on mrm_pkg, mrm_ctrl, mrm_dpath (and mrm_ram below).
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in_data  (mrm_pkg::t_in_item)
//  output    out        o_out_valid / i_out_stall   o_out_data (mrm_pkg::t_out_item)
//
// One transaction at a time. A miss scans the whole searched queue, then
// appends to the other queue (or flags overflow if it is full); a hit scans
// up to the match, then closes the gap. Every entry read goes through the
// single read port of the searched queue's RAM, so the time per transaction
// grows with the fill of the searched queue.
// Reset clears fill counters, handle counter and control; queue RAM contents
// are not cleared, entries past the fill count are never read.
// The result waits in its output register while o_out_valid is high and
// i_out_stall holds it; the next input transaction is taken after it leaves.
module message_receive_matcher #(
    parameter int POSTED_DEPTH     = 32,
    parameter int UNEXPECTED_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mrm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mrm_pkg::t_out_item o_out_data
);

    // Command and status groups between sequencer and datapath
    mrm_pkg::t_ctl_cmd cmd;
    mrm_pkg::t_ctl_sts sts;

    // Sequencer: walks the searched queue, closes the gap after a match,
    // or appends to the other queue, then presents the result.
    mrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Queues, counters and result register
    mrm_dpath #(
        .POSTED_DEPTH     (POSTED_DEPTH),
        .UNEXPECTED_DEPTH (UNEXPECTED_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
